// ----- rtl/core/gbc_pkg.sv -----
// Shared types and opcode constants for the instruction subset core.
`default_nettype none
package gbc_pkg;

   localparam logic [7:0] OP_NOP       = 8'h00;
   localparam logic [7:0] OP_LD_BC_D16 = 8'h01;
   localparam logic [7:0] OP_LD_IBC_A  = 8'h02;
   localparam logic [7:0] OP_INC_BC    = 8'h03;
   localparam logic [7:0] OP_INC_B     = 8'h04;
   localparam logic [7:0] OP_DEC_B     = 8'h05;
   localparam logic [7:0] OP_LD_B_D8   = 8'h06;
   localparam logic [7:0] OP_RLCA      = 8'h07;
   localparam logic [7:0] OP_LD_A16_SP = 8'h08;
   localparam logic [7:0] OP_ADD_HL_BC = 8'h09;
   localparam logic [7:0] OP_LD_SP_D16 = 8'h31;

   typedef struct packed {
      logic [7:0]  opcode;
      logic [7:0]  immediate_low;
      logic [7:0]  immediate_high;
   } req_type;

   typedef struct packed {
      logic [7:0]  a;
      logic [7:0]  f;
      logic [7:0]  b;
      logic [7:0]  c;
      logic [7:0]  h;
      logic [7:0]  l;
      logic [15:0] sp;
      logic [15:0] pc;
      logic [31:0] cycle_total;
   } cpu_state_type;

   typedef struct packed {
      logic        write_enable;
      logic [15:0] write_address;
      logic [7:0]  write_data;
      logic        dual;
      logic [15:0] second_address;
      logic [7:0]  second_data;
      logic [1:0]  instruction_length;
      logic [4:0]  cycles_taken;
      logic        unknown_opcode;
      logic [7:0]  flags_out;
      logic [15:0] program_counter_out;
   } exec_result_type;

endpackage
`default_nettype wire

// ----- rtl/core/gbc_if.sv -----
// Request and response channel interfaces.
`default_nettype none
interface gbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] opcode;
   logic [7:0] immediate_low;
   logic [7:0] immediate_high;

   modport source (output valid, output opcode, output immediate_low,
                   output immediate_high, input ready);
   modport sink   (input valid, input opcode, input immediate_low,
                   input immediate_high, output ready);
endinterface

interface gbc_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_enable;
   logic [15:0] write_address;
   logic [7:0]  write_data;
   logic        last;
   logic [1:0]  instruction_length;
   logic [4:0]  cycles_taken;
   logic        unknown_opcode;
   logic [7:0]  flags_out;
   logic [15:0] program_counter_out;

   modport source (output valid, output write_enable, output write_address,
                   output write_data, output last, output instruction_length,
                   output cycles_taken, output unknown_opcode, output flags_out,
                   output program_counter_out, input ready);
   modport sink   (input valid, input write_enable, input write_address,
                   input write_data, input last, input instruction_length,
                   input cycles_taken, input unknown_opcode, input flags_out,
                   input program_counter_out, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/gbc_execute.sv -----
// Decode and execute of one instruction against the register state.
`default_nettype none
module gbc_execute (
   input  gbc_pkg::req_type         instr,
   input  gbc_pkg::cpu_state_type   cur,
   output gbc_pkg::cpu_state_type   nxt,
   output gbc_pkg::exec_result_type res
);
   import gbc_pkg::*;

   logic [15:0] imm16;
   logic [15:0] bc;
   logic [15:0] hl;
   logic [15:0] bc_inc;
   logic [7:0]  b_inc;
   logic [7:0]  b_dec;
   logic [12:0] half_sum;
   logic [16:0] full_sum;
   logic [7:0]  f;
   logic [1:0]  len;
   logic [4:0]  cyc;

   assign imm16    = {instr.immediate_high, instr.immediate_low};
   assign bc       = {cur.b, cur.c};
   assign hl       = {cur.h, cur.l};
   assign bc_inc   = bc + 16'd1;
   assign b_inc    = cur.b + 8'd1;
   assign b_dec    = cur.b - 8'd1;
   assign half_sum = {1'b0, bc[11:0]} + {1'b0, hl[11:0]};
   assign full_sum = {1'b0, bc} + {1'b0, hl};

   always_comb begin
      nxt = cur;
      f   = cur.f;
      len = 2'd1;
      cyc = 5'd0;
      res = '0;
      case (instr.opcode)
         OP_NOP: begin
            cyc = 5'd4;
         end
         OP_LD_BC_D16: begin
            nxt.c = instr.immediate_low;
            nxt.b = instr.immediate_high;
            len   = 2'd3;
            cyc   = 5'd12;
         end
         OP_LD_IBC_A: begin
            res.write_enable  = 1'b1;
            res.write_address = bc;
            res.write_data    = cur.a;
            cyc               = 5'd8;
         end
         OP_INC_BC: begin
            nxt.b = bc_inc[15:8];
            nxt.c = bc_inc[7:0];
            cyc   = 5'd8;
         end
         OP_INC_B: begin
            nxt.b = b_inc;
            f     = {b_inc == 8'd0, 1'b0, cur.b[3:0] == 4'hF, cur.f[4], 4'd0};
            cyc   = 5'd4;
         end
         OP_DEC_B: begin
            nxt.b = b_dec;
            f     = {b_dec == 8'd0, 1'b1, cur.b[3:0] == 4'h0, cur.f[4], 4'd0};
            cyc   = 5'd4;
         end
         OP_LD_B_D8: begin
            nxt.b = instr.immediate_low;
            len   = 2'd2;
            cyc   = 5'd8;
         end
         OP_RLCA: begin
            nxt.a = {cur.a[6:0], cur.a[7]};
            f     = {3'd0, cur.a[7], 4'd0};
            cyc   = 5'd4;
         end
         OP_LD_A16_SP: begin
            res.write_enable   = 1'b1;
            res.write_address  = imm16;
            res.write_data     = cur.sp[7:0];
            res.dual           = 1'b1;
            res.second_address = imm16 + 16'd1;
            res.second_data    = cur.sp[15:8];
            len                = 2'd3;
            cyc                = 5'd20;
         end
         OP_ADD_HL_BC: begin
            nxt.h = full_sum[15:8];
            nxt.l = full_sum[7:0];
            f     = {cur.f[7], 1'b0, half_sum[12], full_sum[16], 4'd0};
            cyc   = 5'd8;
         end
         OP_LD_SP_D16: begin
            nxt.sp = imm16;
            len    = 2'd3;
            cyc    = 5'd12;
         end
         default: begin
            res.unknown_opcode = 1'b1;
         end
      endcase
      nxt.f                   = {f[7:4], 4'd0};
      nxt.pc                  = cur.pc + {14'd0, len};
      nxt.cycle_total         = cur.cycle_total + {27'd0, cyc};
      res.instruction_length  = len;
      res.cycles_taken        = cyc;
      res.flags_out           = nxt.f;
      res.program_counter_out = nxt.pc;
   end

endmodule
`default_nettype wire

// ----- rtl/core/gbc_result_stage.sv -----
// Result register; splits a two-write instruction into two transactions.
`default_nettype none
module gbc_result_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  gbc_pkg::exec_result_type res,
   output logic                     can_load,
   gbc_rsp_if.source                rsp_if
);
   import gbc_pkg::*;

   logic            valid_ff, valid_in;
   logic            pend_ff, pend_in;
   exec_result_type hold_ff, hold_in;
   logic            last_ff, last_in;
   logic            take;

   assign take     = valid_ff && rsp_if.ready;
   assign can_load = !valid_ff || (rsp_if.ready && !pend_ff);

   always_comb begin
      valid_in = valid_ff;
      pend_in  = pend_ff;
      hold_in  = hold_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         pend_in  = res.dual;
         hold_in  = res;
         last_in  = !res.dual;
      end else if (take && pend_ff) begin
         pend_in               = 1'b0;
         hold_in.write_address = hold_ff.second_address;
         hold_in.write_data    = hold_ff.second_data;
         last_in               = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
      hold_ff <= hold_in;
      last_ff <= last_in;
   end

   assign rsp_if.valid               = valid_ff;
   assign rsp_if.write_enable        = hold_ff.write_enable;
   assign rsp_if.write_address       = hold_ff.write_address;
   assign rsp_if.write_data          = hold_ff.write_data;
   assign rsp_if.last                = last_ff;
   assign rsp_if.instruction_length  = hold_ff.instruction_length;
   assign rsp_if.cycles_taken        = hold_ff.cycles_taken;
   assign rsp_if.unknown_opcode      = hold_ff.unknown_opcode;
   assign rsp_if.flags_out           = hold_ff.flags_out;
   assign rsp_if.program_counter_out = hold_ff.program_counter_out;

endmodule
`default_nettype wire

// ----- rtl/core/gb_cpu_instruction_subset_core.sv -----
// Top level: input register, register state, execute and result stage.
//
//   channel   direction  handshake      payload
//   req_if    in         valid/ready    opcode, immediate_low, immediate_high
//   rsp_if    out        valid/ready    write, last, length, cycles, flags, pc
//
// One instruction is taken per cycle unless rsp_if stalls or a two-write
// instruction is pending; it waits in the input register, executes from there,
// and its result is registered. LD (a16),SP gives two transactions and holds
// the input register until the single result register has given out both.
// Synchronous reset clears all CPU registers and the cycle total.
// A stall on rsp_if holds the result and, once it is full, the input register.
`default_nettype none
module gb_cpu_instruction_subset_core (
   input  logic    clock,
   input  logic    reset,
   gbc_req_if.sink   req_if,
   gbc_rsp_if.source rsp_if
);
   import gbc_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_type         in_data_ff, in_data_in;
   cpu_state_type   state_ff, state_in;
   cpu_state_type   state_next;
   exec_result_type res;
   logic            can_load;
   logic            advance;
   logic            accept;

   assign advance      = in_valid_ff && can_load;
   assign req_if.ready = !in_valid_ff || can_load;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      state_in    = state_ff;
      if (advance) begin
         in_valid_in = 1'b0;
         state_in    = state_next;
      end
      if (accept) begin
         in_valid_in = 1'b1;
         in_data_in  = {req_if.opcode, req_if.immediate_low, req_if.immediate_high};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
      in_data_ff <= in_data_in;
   end

   gbc_execute u_execute (
      .instr (in_data_ff),
      .cur   (state_ff),
      .nxt   (state_next),
      .res   (res)
   );

   gbc_result_stage u_result (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .res      (res),
      .can_load (can_load),
      .rsp_if   (rsp_if)
   );

endmodule
`default_nettype wire

// ----- test/gb_cpu_instruction_subset_core_tb.sv -----
// Self-checking testbench for the instruction subset core: random and directed programs.
`timescale 1ns / 1ps
module gb_cpu_instruction_subset_core_tb;
   import gbc_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int FLAG_Z_BIT = 7;
   localparam int FLAG_N_BIT = 6;
   localparam int FLAG_H_BIT = 5;
   localparam int FLAG_C_BIT = 4;
   localparam logic [7:0] SUBSET_OPS [11] = '{OP_NOP, OP_LD_BC_D16, OP_LD_IBC_A,
      OP_INC_BC, OP_INC_B, OP_DEC_B, OP_LD_B_D8, OP_RLCA, OP_LD_A16_SP,
      OP_ADD_HL_BC, OP_LD_SP_D16};
   localparam logic [7:0] WIDE_OPS [3] = '{OP_LD_BC_D16, OP_LD_SP_D16, OP_LD_A16_SP};

   typedef struct {
      req_type ins;
      bit      calm;
   } stim_type;

   typedef struct packed {
      logic        write_enable;
      logic [15:0] write_address;
      logic [7:0]  write_data;
      logic        last;
      logic [1:0]  instruction_length;
      logic [4:0]  cycles_taken;
      logic        unknown_opcode;
      logic [7:0]  flags_out;
      logic [15:0] program_counter_out;
   } retire_type;

   logic clock;
   logic reset;

   gbc_req_if req_bus ();
   gbc_rsp_if rsp_bus ();

   gb_cpu_instruction_subset_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   stim_type   instr_stream [$];
   retire_type expected_retires [$];

   logic [7:0]  cpu_a;
   logic [7:0]  cpu_f;
   logic [7:0]  cpu_b;
   logic [7:0]  cpu_c;
   logic [7:0]  cpu_h;
   logic [7:0]  cpu_l;
   logic [15:0] cpu_sp;
   logic [15:0] cpu_pc;
   logic [31:0] cpu_cycle_total;

   int          mismatch_count = 0;
   int          idle_left = 0;
   int          stall_left = 0;
   int          quiet_cycles = 0;
   int unsigned tick = 0;
   bit          quiet_mode = 1'b0;
   stim_type    next_item;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   task automatic execute_instruction(input req_type ins);
      logic [15:0] imm;
      logic [15:0] bc;
      logic [15:0] hl;
      logic [16:0] sum;
      logic [12:0] half_sum;
      logic [7:0]  fl;
      logic        msb;
      retire_type  r;
      imm = {ins.immediate_high, ins.immediate_low};
      bc = {cpu_b, cpu_c};
      hl = {cpu_h, cpu_l};
      fl = cpu_f;
      r = '0;
      r.instruction_length = 2'd1;
      case (ins.opcode)
         OP_NOP: r.cycles_taken = 5'd4;
         OP_LD_BC_D16: begin
            cpu_c = ins.immediate_low;
            cpu_b = ins.immediate_high;
            r.instruction_length = 2'd3;
            r.cycles_taken = 5'd12;
         end
         OP_LD_IBC_A: begin
            r.write_enable = 1'b1;
            r.write_address = bc;
            r.write_data = cpu_a;
            r.cycles_taken = 5'd8;
         end
         OP_INC_BC: begin
            {cpu_b, cpu_c} = bc + 16'd1;
            r.cycles_taken = 5'd8;
         end
         OP_INC_B: begin
            fl[FLAG_N_BIT] = 1'b0;
            fl[FLAG_H_BIT] = (cpu_b[3:0] == 4'hF);
            cpu_b = cpu_b + 8'd1;
            fl[FLAG_Z_BIT] = (cpu_b == 8'd0);
            r.cycles_taken = 5'd4;
         end
         OP_DEC_B: begin
            fl[FLAG_N_BIT] = 1'b1;
            fl[FLAG_H_BIT] = (cpu_b[3:0] == 4'h0);
            cpu_b = cpu_b - 8'd1;
            fl[FLAG_Z_BIT] = (cpu_b == 8'd0);
            r.cycles_taken = 5'd4;
         end
         OP_LD_B_D8: begin
            cpu_b = ins.immediate_low;
            r.instruction_length = 2'd2;
            r.cycles_taken = 5'd8;
         end
         OP_RLCA: begin
            msb = cpu_a[7];
            cpu_a = {cpu_a[6:0], msb};
            fl = '0;
            fl[FLAG_C_BIT] = msb;
            r.cycles_taken = 5'd4;
         end
         OP_LD_A16_SP: begin
            r.instruction_length = 2'd3;
            r.cycles_taken = 5'd20;
         end
         OP_ADD_HL_BC: begin
            half_sum = {1'b0, bc[11:0]} + {1'b0, hl[11:0]};
            sum = {1'b0, bc} + {1'b0, hl};
            fl[FLAG_N_BIT] = 1'b0;
            fl[FLAG_H_BIT] = half_sum[12];
            fl[FLAG_C_BIT] = sum[16];
            {cpu_h, cpu_l} = sum[15:0];
            r.cycles_taken = 5'd8;
         end
         OP_LD_SP_D16: begin
            cpu_sp = imm;
            r.instruction_length = 2'd3;
            r.cycles_taken = 5'd12;
         end
         default: r.unknown_opcode = 1'b1;
      endcase
      cpu_f = fl & 8'hF0;
      cpu_pc = cpu_pc + 16'(r.instruction_length);
      cpu_cycle_total = cpu_cycle_total + 32'(r.cycles_taken);
      r.flags_out = cpu_f;
      r.program_counter_out = cpu_pc;
      if (ins.opcode == OP_LD_A16_SP) begin
         r.write_enable = 1'b1;
         r.write_address = imm;
         r.write_data = cpu_sp[7:0];
         r.last = 1'b0;
         expected_retires.push_back(r);
         r.write_address = imm + 16'd1;
         r.write_data = cpu_sp[15:8];
      end
      r.last = 1'b1;
      expected_retires.push_back(r);
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic push_instr(input logic [7:0] op, input logic [7:0] lo, input logic [7:0] hi,
                             input bit calm);
      stim_type s;
      s.ins.opcode = op;
      s.ins.immediate_low = lo;
      s.ins.immediate_high = hi;
      s.calm = calm;
      instr_stream.push_back(s);
   endtask

   function automatic logic [7:0] random_opcode();
      if ($urandom_range(0, 99) < 15) return 8'($urandom_range(0, 255));
      return SUBSET_OPS[$urandom_range(0, 10)];
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         cpu_a = '0;
         cpu_f = '0;
         cpu_b = '0;
         cpu_c = '0;
         cpu_h = '0;
         cpu_l = '0;
         cpu_sp = '0;
         cpu_pc = '0;
         cpu_cycle_total = '0;
      end else begin
         tick++;
         if (req_bus.valid && req_bus.ready) begin
            execute_instruction({req_bus.opcode, req_bus.immediate_low,
                                 req_bus.immediate_high});
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (idle_left > 0) begin
               idle_left--;
               req_bus.valid <= 1'b0;
            end else if (instr_stream.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else if (!quiet_mode && tick[6] && $urandom_range(0, 4) == 0) begin
               idle_left = $urandom_range(0, 2);
               req_bus.valid <= 1'b0;
            end else begin
               next_item = instr_stream.pop_front();
               if (next_item.calm) quiet_mode <= 1'b1;
               req_bus.valid <= 1'b1;
               req_bus.opcode <= next_item.ins.opcode;
               req_bus.immediate_low <= next_item.ins.immediate_low;
               req_bus.immediate_high <= next_item.ins.immediate_high;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      retire_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_retires.size() == 0) begin
               $error("unexpected transaction: address 0x%0h, pc 0x%0h",
                      rsp_bus.write_address, rsp_bus.program_counter_out);
               mismatch_count++;
            end else begin
               want = expected_retires.pop_front();
               check_field("write_enable", want.write_enable, rsp_bus.write_enable);
               check_field("write_address", want.write_address, rsp_bus.write_address);
               check_field("write_data", want.write_data, rsp_bus.write_data);
               check_field("last", want.last, rsp_bus.last);
               check_field("instruction_length", want.instruction_length,
                           rsp_bus.instruction_length);
               check_field("cycles_taken", want.cycles_taken, rsp_bus.cycles_taken);
               check_field("unknown_opcode", want.unknown_opcode, rsp_bus.unknown_opcode);
               check_field("flags_out", want.flags_out, rsp_bus.flags_out);
               check_field("program_counter_out", want.program_counter_out,
                           rsp_bus.program_counter_out);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet_mode && tick[7:6] != 2'b11 && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("gb_cpu_instruction_subset_core_tb: FAIL");
               $finish;
            end
         end
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.opcode = '0;
      req_bus.immediate_low = '0;
      req_bus.immediate_high = '0;
      rsp_bus.ready = 1'b0;
      reset = 1'b1;

      push_instr(OP_NOP, 8'h00, 8'h00, 1'b0);
      push_instr(8'hFF, 8'hFF, 8'hFF, 1'b0);
      push_instr(OP_LD_A16_SP, 8'hFF, 8'hFF, 1'b0);
      push_instr(OP_LD_SP_D16, 8'hFF, 8'hFF, 1'b0);
      push_instr(OP_LD_A16_SP, 8'h00, 8'h00, 1'b0);
      push_instr(OP_LD_BC_D16, 8'hFF, 8'h0F, 1'b0);
      push_instr(OP_INC_B, 8'h00, 8'h00, 1'b0);
      push_instr(OP_DEC_B, 8'h00, 8'h00, 1'b0);
      push_instr(OP_LD_B_D8, 8'hFF, 8'hAA, 1'b0);
      push_instr(OP_INC_B, 8'h00, 8'h00, 1'b0);
      push_instr(OP_DEC_B, 8'h00, 8'h00, 1'b0);
      push_instr(OP_LD_BC_D16, 8'hFF, 8'hFF, 1'b0);
      push_instr(OP_INC_BC, 8'h00, 8'h00, 1'b0);
      push_instr(OP_LD_IBC_A, 8'h00, 8'h00, 1'b0);
      push_instr(OP_LD_BC_D16, 8'hFF, 8'h0F, 1'b0);
      push_instr(OP_ADD_HL_BC, 8'h00, 8'h00, 1'b0);
      push_instr(OP_ADD_HL_BC, 8'h00, 8'h00, 1'b0);
      push_instr(OP_LD_BC_D16, 8'hFF, 8'hFF, 1'b0);
      push_instr(OP_ADD_HL_BC, 8'h00, 8'h00, 1'b0);
      push_instr(OP_RLCA, 8'h00, 8'h00, 1'b0);
      push_instr(8'h10, 8'h00, 8'h00, 1'b0);
      push_instr(8'h80, 8'h55, 8'hAA, 1'b0);
      push_instr(OP_LD_B_D8, 8'h00, 8'h00, 1'b0);
      push_instr(OP_LD_SP_D16, 8'h34, 8'h12, 1'b0);
      push_instr(OP_LD_A16_SP, 8'h00, 8'h80, 1'b0);

      for (int k = 0; k < 900; k++)
         push_instr(random_opcode(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
      for (int k = 0; k < 75; k++)
         push_instr(WIDE_OPS[$urandom_range(0, 2)], 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'b0);
      for (int k = 0; k < 150; k++)
         push_instr(random_opcode(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (instr_stream.size() != 0 || req_bus.valid || expected_retires.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_retires.size() == 0) begin
         $display("gb_cpu_instruction_subset_core_tb: PASS");
      end else begin
         $display("gb_cpu_instruction_subset_core_tb: FAIL");
      end
      $finish;
   end

endmodule
